/* rtl/shng_pkg.sv */
// Shared constants and types of the spatial hash neighbor grid.
package shng_pkg;

   localparam int DEF_TABLE_DEPTH = 2048;
   localparam int DEF_BUCKET_CAP  = 8;
   localparam int DEF_MAX_OBJECTS = 1024;
   localparam int DEF_MAX_RESULTS = 64;
   localparam int DEF_MAX_SPAN    = 3;

   localparam int IDX_W   = 10;
   localparam int POS_W   = 32;
   localparam int RAD_W   = 31;
   localparam int CELL_W  = 31;
   localparam int TSZ_W   = 12;
   localparam int CSR_W   = 32;
   localparam int COORD_W = 34;

   localparam logic [31:0] HASH_KX = 32'd92837111;
   localparam logic [31:0] HASH_KY = 32'd689287499;
   localparam logic [31:0] HASH_KZ = 32'd283923481;

   localparam logic [CELL_W-1:0] CELL_SIZE_RST  = 31'd65536;
   localparam logic [TSZ_W-1:0]  TABLE_SIZE_RST = 12'd2048;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic CSR_CELL_SIZE  = 1'b0;
   localparam logic CSR_TABLE_SIZE = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_CLAMP,
      ST_MUL,
      ST_ACC,
      ST_ABS,
      ST_MOD,
      ST_CNT_RD,
      ST_CNT_WAIT,
      ST_ENT_RD,
      ST_ENT_CHK,
      ST_NEXT_CELL,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_RESP
   } state_type;

endpackage

/* rtl/shng_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module shng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/spatial_hash_neighbor_grid.sv */
// Spatial hash grid for particle neighbor search: insert, query and clear.
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, operation, pos_x/y/z, radius, item_index
//   rsp      out        rsp_valid/rsp_ready, neighbor_index, found, last, flags
//   csr      in         csr_valid/csr_ready, csr_index, csr_data
//
// Each cell coordinate comes from a restoring divider after a setup step; six of them
// per item. Each visited cell then takes three multiply-and-accumulate steps, a modulo,
// a count read and a step to the next cell, plus a read and a check per bucket entry.
// Results are read back from the result RAM and sent one at a time. Clear sweeps the
// count memory entry by entry; reset runs the same sweep before req_ready rises.
// One transaction is worked at a time; rsp stalls simply hold the block.
module spatial_hash_neighbor_grid #(
   parameter int TABLE_DEPTH = shng_pkg::DEF_TABLE_DEPTH,
   parameter int BUCKET_CAP  = shng_pkg::DEF_BUCKET_CAP,
   parameter int MAX_OBJECTS = shng_pkg::DEF_MAX_OBJECTS,
   parameter int MAX_RESULTS = shng_pkg::DEF_MAX_RESULTS,
   parameter int MAX_SPAN    = shng_pkg::DEF_MAX_SPAN
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic signed [shng_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [shng_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [shng_pkg::POS_W-1:0] req_pos_z,
   input  logic [shng_pkg::RAD_W-1:0]        req_radius,
   input  logic [shng_pkg::IDX_W-1:0]        req_item_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [shng_pkg::IDX_W-1:0]        rsp_neighbor_index,
   output logic                              rsp_found,
   output logic                              rsp_last,
   output logic                              rsp_bucket_full,
   output logic                              rsp_truncated,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [shng_pkg::CSR_W-1:0]        csr_data
);
   import shng_pkg::*;

   localparam int CAW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EDEP  = TABLE_DEPTH * BUCKET_CAP;
   localparam int EAW   = (EDEP > 1) ? $clog2(EDEP) : 1;
   localparam int CNTW  = $clog2(BUCKET_CAP + 1);
   localparam int NW    = $clog2(MAX_RESULTS + 1);
   localparam int RAW   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
   localparam int SW    = $clog2(MAX_SPAN + 1);

   state_type state_ff, state_in;
   logic [CAW-1:0]    clr_addr_ff, clr_addr_in;
   logic              clr_op_ff, clr_op_in;
   logic [CELL_W-1:0] cell_size_ff, cell_size_in;
   logic [TSZ_W-1:0]  table_size_ff, table_size_in;

   logic [1:0]        op_ff, op_in;
   logic [POS_W-1:0]  pos_ff [3];
   logic [POS_W-1:0]  pos_in [3];
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [IDX_W-1:0]  item_ff, item_in;
   logic [2:0]        div_sel_ff, div_sel_in;
   logic [5:0]        div_cnt_ff, div_cnt_in;
   logic [32:0]       dvd_ff, dvd_in;
   logic [30:0]       drem_ff, drem_in;
   logic              dneg_ff, dneg_in;
   logic [COORD_W-1:0] lo_ff [3];
   logic [COORD_W-1:0] lo_in [3];
   logic [COORD_W-1:0] hi_ff [3];
   logic [COORD_W-1:0] hi_in [3];
   logic [SW-1:0]     span_ff [3];
   logic [SW-1:0]     span_in [3];
   logic [SW-1:0]     off_ff [3];
   logic [SW-1:0]     off_in [3];
   logic [1:0]        ax_ff, ax_in;
   logic [63:0]       mul_ff, mul_in;
   logic [31:0]       hix_ff, hix_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       mdvd_ff, mdvd_in;
   logic [TSZ_W-1:0]  mrem_ff, mrem_in;
   logic [3:0]        mcnt_ff, mcnt_in;
   logic [CAW-1:0]    hidx_ff, hidx_in;
   logic [CNTW-1:0]   ccnt_ff, ccnt_in;
   logic [CNTW-1:0]   ent_ff, ent_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [NW-1:0]     t_ff, t_in;
   logic              trunc_ff, trunc_in;
   logic              full_ff, full_in;

   logic              cnt_we, cnt_re;
   logic [CAW-1:0]    cnt_waddr;
   logic [CNTW-1:0]   cnt_wdata, cnt_rdata;
   logic              ent_we, ent_re;
   logic [EAW-1:0]    ent_waddr, ent_raddr, ent_base;
   logic [IDX_W-1:0]  ent_rdata;
   logic              res_we, res_re;
   logic [RAW-1:0]    res_waddr, res_raddr;
   logic [IDX_W-1:0]  res_rdata;

   logic [CELL_W-1:0] eff_cell;
   logic [TSZ_W-1:0]  eff_tab;
   logic [32:0]       p33, pos33, rad33;
   logic [31:0]       tr;
   logic              ge;
   logic [32:0]       quo;
   logic [COORD_W-1:0] coord;
   logic [34:0]       diff;
   logic [COORD_W-1:0] cc;
   logic [31:0]       kk;
   logic [TSZ_W-1:0]  r;
   logic [TSZ_W:0]    tm;
   logic              finish;

   assign eff_cell = (cell_size_ff == '0) ? CELL_W'(1) : cell_size_ff;
   assign eff_tab  = (table_size_ff == '0) ? TSZ_W'(1) :
                     ((32'(table_size_ff) > TABLE_DEPTH) ? TSZ_W'(TABLE_DEPTH)
                                                         : table_size_ff);
   assign ent_base = EAW'(hidx_ff) * EAW'(BUCKET_CAP);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_op_in     = clr_op_ff;
      cell_size_in  = cell_size_ff;
      table_size_in = table_size_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      rad_in        = rad_ff;
      item_in       = item_ff;
      div_sel_in    = div_sel_ff;
      div_cnt_in    = div_cnt_ff;
      dvd_in        = dvd_ff;
      drem_in       = drem_ff;
      dneg_in       = dneg_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      span_in       = span_ff;
      off_in        = off_ff;
      ax_in         = ax_ff;
      mul_in        = mul_ff;
      hix_in        = hix_ff;
      acc_in        = acc_ff;
      mdvd_in       = mdvd_ff;
      mrem_in       = mrem_ff;
      mcnt_in       = mcnt_ff;
      hidx_in       = hidx_ff;
      ccnt_in       = ccnt_ff;
      ent_in        = ent_ff;
      n_in          = n_ff;
      t_in          = t_ff;
      trunc_in      = trunc_ff;
      full_in       = full_ff;

      cnt_we    = 1'b0;
      cnt_re    = 1'b0;
      cnt_waddr = hidx_ff;
      cnt_wdata = '0;
      ent_we    = 1'b0;
      ent_re    = 1'b0;
      ent_waddr = ent_base + EAW'(cnt_rdata);
      ent_raddr = ent_base + EAW'(ent_ff);
      res_we    = 1'b0;
      res_re    = 1'b0;
      res_waddr = RAW'(n_ff);
      res_raddr = RAW'(t_ff);

      req_ready          = 1'b0;
      rsp_valid          = 1'b0;
      rsp_neighbor_index = '0;
      rsp_found          = 1'b0;
      rsp_last           = 1'b0;
      rsp_bucket_full    = 1'b0;
      rsp_truncated      = 1'b0;
      csr_ready          = 1'b1;

      pos33 = {pos_ff[div_sel_ff[2:1]][POS_W-1], pos_ff[div_sel_ff[2:1]]};
      rad33 = {2'b00, rad_ff};
      p33   = div_sel_ff[0] ? (pos33 + rad33) : (pos33 - rad33);
      tr    = {drem_ff, dvd_ff[32]};
      ge    = (tr >= {1'b0, eff_cell});
      quo   = {dvd_ff[31:0], ge};
      coord = dneg_ff ? (COORD_W'(0) - {1'b0, quo}) : {1'b0, quo};
      cc    = lo_ff[ax_ff] + COORD_W'(off_ff[ax_ff]);
      diff  = '0;
      tm    = '0;
      r     = mrem_ff;
      finish = 1'b0;
      case (ax_ff)
         2'd0:    kk = HASH_KX;
         2'd1:    kk = HASH_KY;
         default: kk = HASH_KZ;
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_CELL_SIZE:  cell_size_in  = csr_data[CELL_W-1:0];
            CSR_TABLE_SIZE: table_size_in = csr_data[TSZ_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_ff;
            cnt_wdata = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CAW'(TABLE_DEPTH - 1)) begin
               state_in = clr_op_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = req_operation;
               pos_in[0]  = req_pos_x;
               pos_in[1]  = req_pos_y;
               pos_in[2]  = req_pos_z;
               item_in    = req_item_index;
               rad_in     = '0;
               trunc_in   = 1'b0;
               full_in    = 1'b0;
               n_in       = '0;
               div_sel_in = '0;
               case (req_operation)
                  OP_INSERT: begin
                     state_in = (32'(req_item_index) < MAX_OBJECTS) ? ST_DIV_START
                                                                    : ST_RESP;
                  end
                  OP_QUERY: begin
                     rad_in   = req_radius;
                     state_in = ST_DIV_START;
                  end
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     clr_op_in   = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_DIV_START: begin
            dneg_in    = p33[32];
            dvd_in     = p33[32] ? (33'd0 - p33) : p33;
            drem_in    = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            drem_in    = ge ? 31'(tr - {1'b0, eff_cell}) : tr[30:0];
            dvd_in     = quo;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 6'd32) begin
               dneg_in = dneg_ff;
               if (div_sel_ff[0]) begin
                  hi_in[div_sel_ff[2:1]] = coord;
               end else begin
                  lo_in[div_sel_ff[2:1]] = coord;
               end
               if (div_sel_ff == 3'd5) begin
                  state_in = ST_CLAMP;
               end else begin
                  div_sel_in = div_sel_ff + 1'b1;
                  state_in   = ST_DIV_START;
               end
            end
         end
         ST_CLAMP: begin
            for (int a = 0; a < 3; a++) begin
               diff = {hi_ff[a][COORD_W-1], hi_ff[a]} - {lo_ff[a][COORD_W-1], lo_ff[a]};
               if (diff >= 35'(MAX_SPAN)) begin
                  span_in[a] = SW'(MAX_SPAN);
                  trunc_in   = 1'b1;
               end else begin
                  span_in[a] = SW'(diff + 35'd1);
               end
               off_in[a] = '0;
            end
            ax_in    = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_in = {32'd0, cc[31:0]} * {32'd0, kk};
            case (cc[COORD_W-1:32])
               2'b01:   hix_in = kk;
               2'b11:   hix_in = 32'd0 - kk;
               2'b10:   hix_in = 32'd0 - {kk[30:0], 1'b0};
               default: hix_in = '0;
            endcase
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = ((ax_ff == 2'd0) ? 64'd0 : acc_ff) ^ (mul_ff + {hix_ff, 32'd0});
            if (ax_ff == 2'd2) begin
               state_in = ST_ABS;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_ABS: begin
            mdvd_in  = acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
            mrem_in  = '0;
            mcnt_in  = '0;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            for (int s = 0; s < 4; s++) begin
               tm = {r, mdvd_ff[63 - s]};
               r  = (tm >= {1'b0, eff_tab}) ? TSZ_W'(tm - {1'b0, eff_tab}) : tm[TSZ_W-1:0];
            end
            mrem_in = r;
            mdvd_in = {mdvd_ff[59:0], 4'd0};
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 4'd15) begin
               hidx_in  = CAW'(r);
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            cnt_re   = 1'b1;
            state_in = ST_CNT_WAIT;
         end
         ST_CNT_WAIT: begin
            if (op_ff == OP_INSERT) begin
               if (32'(cnt_rdata) >= BUCKET_CAP) begin
                  full_in = 1'b1;
               end else begin
                  ent_we    = 1'b1;
                  cnt_we    = 1'b1;
                  cnt_wdata = CNTW'(cnt_rdata + 1'b1);
               end
               state_in = ST_RESP;
            end else begin
               ccnt_in  = cnt_rdata;
               ent_in   = '0;
               state_in = (cnt_rdata == '0) ? ST_NEXT_CELL : ST_ENT_RD;
            end
         end
         ST_ENT_RD: begin
            ent_re   = 1'b1;
            state_in = ST_ENT_CHK;
         end
         ST_ENT_CHK: begin
            ent_in   = ent_ff + 1'b1;
            state_in = (ent_ff == ccnt_ff - 1'b1) ? ST_NEXT_CELL : ST_ENT_RD;
            if (ent_rdata != item_ff) begin
               if (32'(n_ff) >= MAX_RESULTS) begin
                  trunc_in = 1'b1;
                  finish   = 1'b1;
               end else begin
                  res_we = 1'b1;
                  n_in   = n_ff + 1'b1;
               end
            end
         end
         ST_NEXT_CELL: begin
            ax_in    = '0;
            state_in = ST_MUL;
            if (SW'(off_ff[2] + 1'b1) < span_ff[2]) begin
               off_in[2] = off_ff[2] + 1'b1;
            end else if (SW'(off_ff[1] + 1'b1) < span_ff[1]) begin
               off_in[1] = off_ff[1] + 1'b1;
               off_in[2] = '0;
            end else if (SW'(off_ff[0] + 1'b1) < span_ff[0]) begin
               off_in[0] = off_ff[0] + 1'b1;
               off_in[1] = '0;
               off_in[2] = '0;
            end else begin
               finish = 1'b1;
            end
         end
         ST_EMIT_RD: begin
            res_re   = 1'b1;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid          = 1'b1;
            rsp_neighbor_index = res_rdata;
            rsp_found          = 1'b1;
            rsp_last           = (t_ff == n_ff - 1'b1);
            rsp_truncated      = trunc_ff;
            if (rsp_ready) begin
               t_in     = t_ff + 1'b1;
               state_in = (t_ff == n_ff - 1'b1) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_RESP: begin
            rsp_valid       = 1'b1;
            rsp_last        = 1'b1;
            rsp_bucket_full = full_ff;
            rsp_truncated   = trunc_ff;
            clr_op_in       = 1'b0;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         t_in     = '0;
         state_in = (n_ff == '0) ? ST_RESP : ST_EMIT_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         clr_op_ff     <= 1'b0;
         cell_size_ff  <= CELL_SIZE_RST;
         table_size_ff <= TABLE_SIZE_RST;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         clr_op_ff     <= clr_op_in;
         cell_size_ff  <= cell_size_in;
         table_size_ff <= table_size_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      rad_ff     <= rad_in;
      item_ff    <= item_in;
      div_sel_ff <= div_sel_in;
      div_cnt_ff <= div_cnt_in;
      dvd_ff     <= dvd_in;
      drem_ff    <= drem_in;
      dneg_ff    <= dneg_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      span_ff    <= span_in;
      off_ff     <= off_in;
      ax_ff      <= ax_in;
      mul_ff     <= mul_in;
      hix_ff     <= hix_in;
      acc_ff     <= acc_in;
      mdvd_ff    <= mdvd_in;
      mrem_ff    <= mrem_in;
      mcnt_ff    <= mcnt_in;
      hidx_ff    <= hidx_in;
      ccnt_ff    <= ccnt_in;
      ent_ff     <= ent_in;
      n_ff       <= n_in;
      t_ff       <= t_in;
      trunc_ff   <= trunc_in;
      full_ff    <= full_in;
   end

   shng_ram #(.WIDTH(CNTW), .DEPTH(TABLE_DEPTH)) u_counts (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .re    (cnt_re),
      .raddr (hidx_ff),
      .rdata (cnt_rdata)
   );

   shng_ram #(.WIDTH(IDX_W), .DEPTH(EDEP)) u_entries (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (item_ff),
      .re    (ent_re),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   shng_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RESULTS)) u_results (
      .clock (clock),
      .we    (res_we),
      .waddr (res_waddr),
      .wdata (ent_rdata),
      .re    (res_re),
      .raddr (res_raddr),
      .rdata (res_rdata)
   );

endmodule

/* tb/shng_checker.sv */
// Checker for the spatial hash neighbor grid: predicts and compares response transactions.
`timescale 1ns / 1ps
module shng_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic signed [shng_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [shng_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [shng_pkg::POS_W-1:0] req_pos_z,
   input  logic [shng_pkg::RAD_W-1:0]        req_radius,
   input  logic [shng_pkg::IDX_W-1:0]        req_item_index,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [shng_pkg::IDX_W-1:0]        rsp_neighbor_index,
   input  logic                              rsp_found,
   input  logic                              rsp_last,
   input  logic                              rsp_bucket_full,
   input  logic                              rsp_truncated,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [shng_pkg::CSR_W-1:0]        csr_data,
   output int                                fail_count,
   output int                                pending
);
   import shng_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;
   localparam int CAP   = DEF_BUCKET_CAP;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             found;
      logic             last;
      logic             full;
      logic             trunc;
   } neighbor_type;

   neighbor_type      expected_q[$];
   logic [IDX_W-1:0]  slot_mem[DEPTH*CAP];
   int                fill[DEPTH];
   logic [CELL_W-1:0] cell_size;
   logic [TSZ_W-1:0]  table_size;

   function automatic longint cell_of(longint p);
      longint c;
      c = (cell_size == 0) ? 1 : longint'(cell_size);
      return p / c;
   endfunction

   function automatic int bucket_of(longint x, longint y, longint z);
      longint unsigned h, t;
      h = (longint'(unsigned'(x)) * 64'(HASH_KX)) ^ (longint'(unsigned'(y)) * 64'(HASH_KY))
          ^ (longint'(unsigned'(z)) * 64'(HASH_KZ));
      if (h[63]) h = -h;
      t = (table_size == 0) ? 1 : (table_size > DEPTH) ? DEPTH : table_size;
      return int'(h % t);
   endfunction

   function automatic void push_one(logic [IDX_W-1:0] idx, logic fnd, logic lst,
                                    logic full, logic trunc);
      neighbor_type n;
      n.idx = idx; n.found = fnd; n.last = lst; n.full = full; n.trunc = trunc;
      expected_q.insert(expected_q.size(), n);
   endfunction

   task automatic predict_search(logic [1:0] op, longint px, longint py, longint pz,
                                 longint r, logic [IDX_W-1:0] item);
      int               h, c;
      logic             trunc, stop;
      longint           lo[3], hi[3];
      logic [IDX_W-1:0] hits[$];
      logic [IDX_W-1:0] v;
      trunc = 0; stop = 0;
      case (op)
         OP_INSERT: begin
            h = bucket_of(cell_of(px), cell_of(py), cell_of(pz));
            if (fill[h] >= CAP) begin
               push_one('0, 0, 1, 1, 0);
            end else begin
               slot_mem[h*CAP + fill[h]] = item;
               fill[h]++;
               push_one('0, 0, 1, 0, 0);
            end
         end
         OP_CLEAR: begin
            foreach (fill[i]) fill[i] = 0;
            push_one('0, 0, 1, 0, 0);
         end
         OP_QUERY: begin
            lo[0] = cell_of(px - r); hi[0] = cell_of(px + r);
            lo[1] = cell_of(py - r); hi[1] = cell_of(py + r);
            lo[2] = cell_of(pz - r); hi[2] = cell_of(pz + r);
            for (int a = 0; a < 3; a++) begin
               if (hi[a] - lo[a] + 1 > DEF_MAX_SPAN) begin
                  hi[a] = lo[a] + DEF_MAX_SPAN - 1;
                  trunc = 1;
               end
            end
            for (longint i = lo[0]; i <= hi[0] && !stop; i++)
               for (longint j = lo[1]; j <= hi[1] && !stop; j++)
                  for (longint k = lo[2]; k <= hi[2] && !stop; k++) begin
                     h = bucket_of(i, j, k);
                     c = (fill[h] > CAP) ? CAP : fill[h];
                     for (int e = 0; e < c; e++) begin
                        v = slot_mem[h*CAP + e];
                        if (v == item) continue;
                        if (hits.size() >= DEF_MAX_RESULTS) begin
                           trunc = 1;
                           stop = 1;
                           break;
                        end
                        hits.insert(hits.size(), v);
                     end
                  end
            if (hits.size() == 0) push_one('0, 0, 1, 0, trunc);
            foreach (hits[t]) push_one(hits[t], 1, t == hits.size() - 1, 0, trunc);
         end
         default: push_one('0, 0, 1, 0, 0);
      endcase
   endtask

   always @(posedge clock) begin
      neighbor_type want;
      if (reset) begin
         foreach (fill[i]) fill[i] = 0;
         cell_size  = CELL_SIZE_RST;
         table_size = TABLE_SIZE_RST;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CELL_SIZE) cell_size = csr_data[CELL_W-1:0];
            else table_size = csr_data[TSZ_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected response transaction, neighbor_index %0d", rsp_neighbor_index);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_neighbor_index !== want.idx) begin
                  $error("neighbor_index: expected %0d, got %0d", want.idx, rsp_neighbor_index);
                  fail_count++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
               if (rsp_bucket_full !== want.full) begin
                  $error("bucket_full: expected %0d, got %0d", want.full, rsp_bucket_full);
                  fail_count++;
               end
               if (rsp_truncated !== want.trunc) begin
                  $error("truncated: expected %0d, got %0d", want.trunc, rsp_truncated);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_search(req_operation, longint'(req_pos_x), longint'(req_pos_y),
                           longint'(req_pos_z), longint'(req_radius), req_item_index);
      end
      pending = expected_q.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top: stimulus, idling, watchdog and verdict for the spatial hash neighbor grid.
`timescale 1ns / 1ps
module tb;
   import shng_pkg::*;

   localparam logic [1:0] OP_NOP = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int N_PHASES = 6;

   logic                     clock, reset;
   logic                     req_valid, req_ready;
   logic [1:0]               req_operation;
   logic signed [POS_W-1:0]  req_pos_x, req_pos_y, req_pos_z;
   logic [RAD_W-1:0]         req_radius;
   logic [IDX_W-1:0]         req_item_index;
   logic                     rsp_valid, rsp_ready;
   logic [IDX_W-1:0]         rsp_neighbor_index;
   logic                     rsp_found, rsp_last, rsp_bucket_full, rsp_truncated;
   logic                     csr_valid, csr_ready, csr_index;
   logic [CSR_W-1:0]         csr_data;
   int                       fail_count, pending, quiet;
   logic                     calm;
   longint                   cell_now;

   spatial_hash_neighbor_grid u_dut (.*);
   shng_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(0, 99) >= 32);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_item(logic [1:0] op, longint x, longint y, longint z, longint r,
                            int idx);
      while (!calm && $urandom_range(0, 99) < 32) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_operation  <= op;
      req_pos_x      <= x[31:0];
      req_pos_y      <= y[31:0];
      req_pos_z      <= z[31:0];
      req_radius     <= r[30:0];
      req_item_index <= idx[9:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CSR_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_item();
      int     pick;
      longint half;
      half = (cell_now / 2 > 1) ? cell_now / 2 : 1;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         send_item(OP_INSERT, half * $urandom_range(0, 8) - 4 * half,
                   half * $urandom_range(0, 8) - 4 * half,
                   half * $urandom_range(0, 8) - 4 * half, 0, $urandom_range(0, 40));
      else if (pick < 80)
         send_item(OP_QUERY, half * $urandom_range(0, 8) - 4 * half,
                   half * $urandom_range(0, 8) - 4 * half,
                   half * $urandom_range(0, 8) - 4 * half,
                   (half * $urandom_range(0, 4)) & 64'h7FFFFFFF, $urandom_range(0, 40));
      else if (pick < 83)
         send_item(OP_CLEAR, $signed($urandom), $signed($urandom), $signed($urandom),
                   $urandom & 32'h7FFFFFFF, $urandom_range(0, 1023));
      else if (pick < 86)
         send_item(OP_NOP, $signed($urandom), $signed($urandom), $signed($urandom),
                   $urandom & 32'h7FFFFFFF, $urandom_range(0, 1023));
      else
         send_item($urandom_range(0, 1) ? OP_INSERT : OP_QUERY, $signed($urandom),
                   $signed($urandom), $signed($urandom), $urandom & 32'h7FFFFFFF,
                   $urandom_range(0, 1023));
   endtask

   initial begin
      longint cells[N_PHASES];
      int     tables[N_PHASES];
      longint u;
      cells  = '{65536, 1, 2147483647, 262144, 32768, 65536};
      tables = '{2048, 1, 0, 4095, 7, 2};
      reset = 1; calm = 0; cell_now = 65536;
      req_valid = 0; req_operation = OP_INSERT; req_pos_x = 0; req_pos_y = 0; req_pos_z = 0;
      req_radius = 0; req_item_index = 0;
      csr_valid = 0; csr_index = CSR_CELL_SIZE; csr_data = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int p = 0; p < N_PHASES; p++) begin
         calm = (p == 3);
         cell_now = cells[p];
         write_reg(CSR_CELL_SIZE, CSR_W'(cells[p]) | ({31'd0, 1'($urandom)} << 31));
         write_reg(CSR_TABLE_SIZE, tables[p] | ($urandom & 32'hFFFFF000));
         send_item(OP_CLEAR, 0, 0, 0, 0, 0);
         if (p == 0) begin
            u = 65536;
            send_item(OP_QUERY, 0, 0, 0, 0, 0);
            send_item(OP_INSERT, 0, 0, 0, 0, 5);
            send_item(OP_INSERT, u / 2, u / 2, u / 2, 0, 6);
            send_item(OP_INSERT, -u / 2, -u / 2, -u / 2, 0, 7);
            send_item(OP_QUERY, 0, 0, 0, 0, 5);
            for (int i = 0; i < 9; i++) send_item(OP_INSERT, 10 * u, 3 * u, -4 * u, 0, 100 + i);
            send_item(OP_QUERY, 10 * u, 3 * u, -4 * u, u, 1023);
            send_item(OP_NOP, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 1023);
            send_item(OP_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1023);
            send_item(OP_INSERT, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 0, 0);
            send_item(OP_QUERY, 32'h7FFFFFFF, -64'sd2147483648, 0, 31'h7FFFFFFF, 0);
            send_item(OP_CLEAR, 0, 0, 0, 0, 0);
            send_item(OP_QUERY, 0, 0, 0, u, 0);
         end else if (p == 1) begin
            for (int i = 0; i < 8; i++) send_item(OP_INSERT, i, -i, i, 0, 200 + i);
            send_item(OP_QUERY, 0, 0, 0, 1, 1000);
         end
         for (int i = 0; i < 22; i++) random_item();
         drain();
      end
      if (fail_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
